>>> rtl/fwcl_pkg.sv
// Shared widths, types and helpers for the four-wheel command limiter.
package fwcl_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int CMD_IN_W   = 14;
  localparam int DUTY_W     = 13;
  localparam int OFF_W      = 13;
  localparam int CMD_W      = 15;
  localparam int MAG_W      = 15;
  localparam int NUM_W      = 12;
  localparam int PROD_W     = MAG_W + NUM_W;
  localparam int Q_W        = 13;
  localparam int LIMIT      = 3200;
  localparam int DUTY_MID   = 3200;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [0:0] {
    CFG_ROT_EN  = 1'b0,
    CFG_ROT_OFF = 1'b1
  } cfg_idx_t;

  typedef logic [NUM_WHEELS-1:0][CMD_W-1:0]  cmd_vec_t;
  typedef logic [NUM_WHEELS-1:0][MAG_W-1:0]  mag_vec_t;
  typedef logic [NUM_WHEELS-1:0][PROD_W-1:0] prod_vec_t;
  typedef logic [NUM_WHEELS-1:0][Q_W-1:0]    quo_vec_t;

  typedef struct packed {
    logic     active;
    cmd_vec_t cmd;
  } side_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [CMD_W:0] v);
    logic signed [CMD_W:0] a;
    a = (v < 0) ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  function automatic logic signed [OFF_W-1:0] clamp_off(input logic signed [OFF_W-1:0] v);
    logic signed [OFF_W-1:0] r;
    if (v > OFF_W'(LIMIT)) begin
      r = OFF_W'(LIMIT);
    end else if (v < -OFF_W'(LIMIT)) begin
      r = -OFF_W'(LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/fwcl_div.sv
// Four-lane restoring divider, one quotient bit per pipeline stage, shared divisor.
module fwcl_div
  import fwcl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_valid,
  input  prod_vec_t in_dividend,
  input  logic [MAG_W-1:0] in_divisor,
  input  side_t     in_side,
  output logic      out_valid,
  output quo_vec_t  out_quot,
  output side_t     out_side
);

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int Bit = Q_W - 1 - k;
    logic             v_in;
    prod_vec_t        rem_in;
    quo_vec_t         quo_in;
    logic [MAG_W-1:0] dvs_in;
    side_t            side_in;
    logic [PROD_W-1:0] dsh;
    prod_vec_t        rem_nxt;
    quo_vec_t         quo_nxt;
    logic             vld_r;
    prod_vec_t        rem_r;
    quo_vec_t         quo_r;
    logic [MAG_W-1:0] dvs_r;
    side_t            side_r;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_dividend;
      assign quo_in  = '0;
      assign dvs_in  = in_divisor;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = g_stage[k-1].vld_r;
      assign rem_in  = g_stage[k-1].rem_r;
      assign quo_in  = g_stage[k-1].quo_r;
      assign dvs_in  = g_stage[k-1].dvs_r;
      assign side_in = g_stage[k-1].side_r;
    end

    assign dsh = PROD_W'(dvs_in) << Bit;

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int w = 0; w < NUM_WHEELS; w++) begin
        if (rem_in[w] >= dsh) begin
          rem_nxt[w]      = rem_in[w] - dsh;
          quo_nxt[w][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        dvs_r  <= dvs_in;
        side_r <= side_in;
      end
    end
  end

  assign out_valid = g_stage[Q_W-1].vld_r;
  assign out_quot  = g_stage[Q_W-1].quo_r;
  assign out_side  = g_stage[Q_W-1].side_r;

endmodule

>>> rtl/fwcl_pass.sv
// One limiting pass: peak search, scale product, pipelined divide, clamp and offset.
module fwcl_pass
  import fwcl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  cmd_vec_t                in_cmd,
  input  logic signed [OFF_W-1:0] ref_off,
  input  logic [NUM_W-1:0]        num,
  input  logic                    gate,
  input  logic signed [OFF_W-1:0] post_off,
  output logic                    out_valid,
  output cmd_vec_t                out_cmd
);

  logic     s0_v_r;
  cmd_vec_t s0_cmd_r;
  mag_vec_t s0_mag_r;
  mag_vec_t s0_mag_nxt;

  logic             s1_v_r;
  cmd_vec_t         s1_cmd_r;
  logic [MAG_W-1:0] s1_mx_r;
  logic             s1_act_r;
  logic [MAG_W-1:0] mx_a;
  logic [MAG_W-1:0] mx_b;
  logic [MAG_W-1:0] s1_mx_nxt;

  logic             s2_v_r;
  prod_vec_t        s2_prod_r;
  logic [MAG_W-1:0] s2_mx_r;
  side_t            s2_side_r;
  prod_vec_t        s2_prod_nxt;

  logic     dv_valid;
  quo_vec_t dv_quot;
  side_t    dv_side;

  logic     out_v_r;
  cmd_vec_t out_cmd_r;
  cmd_vec_t out_cmd_nxt;

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      s0_mag_nxt[w] = mag_of($signed({in_cmd[w][CMD_W-1], in_cmd[w]})
                             - $signed({{(CMD_W+1-OFF_W){ref_off[OFF_W-1]}}, ref_off}));
    end
  end

  always_comb begin
    mx_a      = (s0_mag_r[0] > s0_mag_r[1]) ? s0_mag_r[0] : s0_mag_r[1];
    mx_b      = (s0_mag_r[2] > s0_mag_r[3]) ? s0_mag_r[2] : s0_mag_r[3];
    s1_mx_nxt = (mx_a > mx_b) ? mx_a : mx_b;
  end

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      s2_prod_nxt[w] = PROD_W'(mag_of($signed({s1_cmd_r[w][CMD_W-1], s1_cmd_r[w]})))
                       * PROD_W'(num);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r  <= in_valid;
      s1_v_r  <= s0_v_r;
      s2_v_r  <= s1_v_r;
      out_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cmd_r         <= in_cmd;
      s0_mag_r         <= s0_mag_nxt;
      s1_cmd_r         <= s0_cmd_r;
      s1_mx_r          <= s1_mx_nxt;
      s1_act_r         <= gate && (s1_mx_nxt > MAG_W'(LIMIT));
      s2_prod_r        <= s2_prod_nxt;
      s2_mx_r          <= s1_mx_r;
      s2_side_r.active <= s1_act_r;
      s2_side_r.cmd    <= s1_cmd_r;
      out_cmd_r        <= out_cmd_nxt;
    end
  end

  fwcl_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (s2_v_r),
    .in_dividend (s2_prod_r),
    .in_divisor  (s2_mx_r),
    .in_side     (s2_side_r),
    .out_valid   (dv_valid),
    .out_quot    (dv_quot),
    .out_side    (dv_side)
  );

  always_comb begin
    logic [Q_W-1:0]          qc;
    logic signed [CMD_W-1:0] scaled;
    logic signed [CMD_W-1:0] sel;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      qc     = (dv_quot[w] > Q_W'(LIMIT)) ? Q_W'(LIMIT) : dv_quot[w];
      scaled = dv_side.cmd[w][CMD_W-1] ? -$signed(CMD_W'(qc)) : $signed(CMD_W'(qc));
      sel    = dv_side.active ? scaled : $signed(dv_side.cmd[w]);
      out_cmd_nxt[w] = CMD_W'(sel - $signed({{(CMD_W-OFF_W){post_off[OFF_W-1]}}, post_off}));
    end
  end

  assign out_valid = out_v_r;
  assign out_cmd   = out_cmd_r;

endmodule

>>> rtl/four_wheel_command_limiter_pwm_core.sv
// Top level of the four-wheel command limiter with PWM duty output.
//
//   port group | dir | contents
//   in_*       | in  | four signed wheel commands, one set per item
//   out_*      | out | four PWM duty values, one set per item
//   cfg_*      | in  | rotation enable and rotation offset writes
//
// One item per cycle unless a held result stalls the pipeline; out_tvalid rises after both passes and the output reg.
// Each pass: offset magnitudes, peak, scale product, 13 divider stages, clamp.
// Synchronous active-low reset clears valid bits and both registers.
// A held result stalls every stage together; in_tready follows the output register.
module four_wheel_command_limiter_pwm_core
  import fwcl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // wheel_one_cmd, wheel_two_cmd, wheel_three_cmd, wheel_four_cmd (14 bits each)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // wheel_one_duty, wheel_two_duty, wheel_three_duty, wheel_four_duty (13 bits each), zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [OFF_W-1:0]      cfg_wdata
);

  logic                    rot_en_r;
  logic signed [OFF_W-1:0] rot_off_r;
  logic signed [OFF_W-1:0] off_eff;
  logic [NUM_W-1:0]        num1;
  logic                    adv;
  cmd_vec_t                in_cmd;
  logic                    p1_valid;
  cmd_vec_t                p1_cmd;
  logic                    p2_valid;
  cmd_vec_t                p2_cmd;
  logic                    out_tvalid_r;
  logic [NUM_WHEELS-1:0][DUTY_W-1:0] duty_r;
  logic [NUM_WHEELS-1:0][DUTY_W-1:0] duty_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_en_r  <= 1'b0;
      rot_off_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROT_EN:  rot_en_r  <= cfg_wdata[0];
        CFG_ROT_OFF: rot_off_r <= $signed(cfg_wdata);
        default:     rot_en_r  <= rot_en_r;
      endcase
    end
  end

  always_comb begin
    logic signed [OFF_W-1:0] c;
    c       = clamp_off(rot_off_r);
    off_eff = rot_en_r ? c : '0;
    num1    = NUM_W'(LIMIT) - NUM_W'(mag_of(CMD_W'(off_eff) + $signed((CMD_W+1)'(0))));
  end

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      in_cmd[w] = {in_tdata[w*CMD_IN_W + CMD_IN_W - 1], in_tdata[w*CMD_IN_W +: CMD_IN_W]};
    end
  end

  assign adv       = out_tready || !out_tvalid_r;
  assign in_tready = adv;

  fwcl_pass u_pass_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_cmd    (in_cmd),
    .ref_off   (off_eff),
    .num       (num1),
    .gate      (rot_en_r),
    .post_off  (off_eff),
    .out_valid (p1_valid),
    .out_cmd   (p1_cmd)
  );

  fwcl_pass u_pass_lim (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (p1_valid),
    .in_cmd    (p1_cmd),
    .ref_off   ('0),
    .num       (NUM_W'(LIMIT)),
    .gate      (1'b1),
    .post_off  ('0),
    .out_valid (p2_valid),
    .out_cmd   (p2_cmd)
  );

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      duty_nxt[w] = DUTY_W'($signed(p2_cmd[w]) + $signed(CMD_W'(DUTY_MID)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      duty_r <= duty_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_DATA_W - NUM_WHEELS*DUTY_W)'(0), duty_r};

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (duty_r[0] <= DUTY_W'(2*DUTY_MID)) && (duty_r[1] <= DUTY_W'(2*DUTY_MID))
                && (duty_r[2] <= DUTY_W'(2*DUTY_MID)) && (duty_r[3] <= DUTY_W'(2*DUTY_MID)))
    else $error("duty out of range");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(p2_valid) && $stable(p1_valid) && (!p2_valid || $stable(p2_cmd)))
    else $error("pipeline moved during stall");

endmodule

>>> tb/tb_four_wheel_command_limiter_pwm_core.sv
// Self-checking testbench for the four-wheel command limiter: directed table, then random sets.
`timescale 1ns / 100ps

module tb_four_wheel_command_limiter_pwm_core;
  import fwcl_pkg::*;

  typedef logic [NUM_WHEELS-1:0][CMD_IN_W-1:0] cmd_set_t;
  typedef logic [NUM_WHEELS-1:0][DUTY_W-1:0]   duty_set_t;

  typedef struct packed {
    int en;
    int off;
    int w1;
    int w2;
    int w3;
    int w4;
    int typed;
    int d1;
    int d2;
    int d3;
    int d4;
  } dir_row_t;

  localparam int NUM_DIRECTED = 20;
  localparam int PHASES       = 3;
  localparam int SETTINGS_PER_PHASE = 11;
  localparam int SETS_PER_SETTING   = 47;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int EXTREMES [5] = '{8191, -8192, 3200, -3200, 0};

  // en, offset, wheel commands one to four, typed, duties one to four
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{0,     0,     0,     0,     0,     0, 1, 3200, 3200, 3200, 3200},
    '{0,     0,  3200, -3200,     0,   100, 1, 6400,    0, 3200, 3300},
    '{0,     0,  8191, -8192,     0,     0, 1, 6399,    0, 3200, 3200},
    '{0,     0,  3201,     0,     0,     0, 1, 6400, 3200, 3200, 3200},
    '{0,     0, -8192, -8192, -8192, -8192, 1,    0,    0,    0,    0},
    '{0,     0,  8191,  8191,  8191,  8191, 1, 6400, 6400, 6400, 6400},
    '{0,     0,  5000, -2500,  1250,  -100, 0,    0,    0,    0,    0},
    '{1,     0,  8191, -8192,     0,     0, 1, 6399,    0, 3200, 3200},
    '{1,     0,  1000,  2000, -3000,     0, 0,    0,    0,    0,    0},
    '{1,   800,     0,     0,     0,     0, 1, 2400, 2400, 2400, 2400},
    '{1,   800,  8191,  8191,  8191,  8191, 0,    0,    0,    0,    0},
    '{1,   800,  4000, -4000,   800,  -800, 0,    0,    0,    0,    0},
    '{1, -3200,  1234, -5678,  8191, -8192, 1, 6400, 6400, 6400, 6400},
    '{1, -3200, -3200, -3200, -3200, -3200, 1, 3200, 3200, 3200, 3200},
    '{1,  4095,  3200,  3200,  3200,  3200, 1, 3200, 3200, 3200, 3200},
    '{1,  4095,     0, -8192,   100,  8191, 0,    0,    0,    0,    0},
    '{1, -4096,     0,     0,     0,     0, 1, 6400, 6400, 6400, 6400},
    '{1, -4096,     5,    -5,  3000, -3000, 0,    0,    0,    0,    0},
    '{0, -4096,   100,   200,  -300,   400, 1, 3300, 3400, 2900, 3600},
    '{0, -4096,  8191,     0,     0,    -1, 0,    0,    0,    0,    0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [0:0]            cfg_index = CFG_ROT_EN;
  logic [OFF_W-1:0]      cfg_wdata = '0;

  logic                     rot_en = 1'b0;
  logic signed [OFF_W-1:0]  rot_off = '0;
  duty_set_t                pending_duties [$];
  duty_set_t                got_duty;
  duty_set_t                want_duty;
  int                       src_idle_pct = 0;
  int                       dst_stall_pct = 0;
  int                       mismatch_count = 0;
  int                       sets_sent = 0;
  int                       results_checked = 0;
  int                       settings_used = 0;
  int                       cycles = 0;

  four_wheel_command_limiter_pwm_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sat_limit(longint v);
    if (v > LIMIT) begin
      return LIMIT;
    end
    if (v < -LIMIT) begin
      return -LIMIT;
    end
    return v;
  endfunction

  function automatic duty_set_t limit_to_duty(cmd_set_t cmds, logic en,
                                              logic signed [OFF_W-1:0] off_reg);
    longint    c [NUM_WHEELS];
    longint    off;
    longint    peak;
    longint    num;
    duty_set_t d;
    int        i;
    for (i = 0; i < NUM_WHEELS; i++) begin
      c[i] = longint'($signed(cmds[i]));
    end
    if (en) begin
      off = sat_limit(longint'(off_reg));
      peak = 0;
      for (i = 0; i < NUM_WHEELS; i++) begin
        if (mag(c[i] - off) > peak) begin
          peak = mag(c[i] - off);
        end
      end
      if (peak > LIMIT) begin
        num = LIMIT - mag(off);
        for (i = 0; i < NUM_WHEELS; i++) begin
          c[i] = sat_limit((c[i] * num) / peak);
        end
      end
      for (i = 0; i < NUM_WHEELS; i++) begin
        c[i] = c[i] - off;
      end
    end
    peak = 0;
    for (i = 0; i < NUM_WHEELS; i++) begin
      if (mag(c[i]) > peak) begin
        peak = mag(c[i]);
      end
    end
    if (peak > LIMIT) begin
      for (i = 0; i < NUM_WHEELS; i++) begin
        c[i] = sat_limit((c[i] * LIMIT) / peak);
      end
    end
    for (i = 0; i < NUM_WHEELS; i++) begin
      d[i] = DUTY_W'(DUTY_MID + c[i]);
    end
    return d;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_cmds(input cmd_set_t cmds, input duty_set_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cmds;
    do @(posedge clk); while (!in_tready);
    pending_duties.push_back(want);
    sets_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until the pipeline is empty, then write both registers.
  task automatic set_rotation(input logic en, input logic [OFF_W-1:0] off);
    in_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ROT_EN;
    cfg_wdata <= OFF_W'(en);
    @(negedge clk);
    cfg_index <= CFG_ROT_OFF;
    cfg_wdata <= off;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rot_en  = en;
    rot_off = off;
    settings_used++;
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= dst_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_duty = out_tdata[NUM_WHEELS*DUTY_W-1:0];
      if (pending_duties.size() == 0) begin
        $display("%0t unexpected duty set: expected none, got %h", $time, got_duty);
        mismatch_count++;
      end else begin
        want_duty = pending_duties.pop_front();
        for (int w = 0; w < NUM_WHEELS; w++) begin
          if (got_duty[w] !== want_duty[w]) begin
            $display("%0t wheel %0d duty: expected %0d, got %0d",
                     $time, w + 1, want_duty[w], got_duty[w]);
            mismatch_count++;
          end
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d duty sets outstanding", $time, pending_duties.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    dir_row_t           row;
    cmd_set_t           cmds;
    duty_set_t          want;
    logic               en;
    logic [OFF_W-1:0]   off;
    int                 v;
    src_idle_pct  = 8;
    dst_stall_pct = 58;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = DIRECTED[r];
      if (1'(row.en) !== rot_en || OFF_W'(row.off) !== rot_off) begin
        set_rotation(1'(row.en), OFF_W'(row.off));
      end
      cmds[0] = CMD_IN_W'(row.w1);
      cmds[1] = CMD_IN_W'(row.w2);
      cmds[2] = CMD_IN_W'(row.w3);
      cmds[3] = CMD_IN_W'(row.w4);
      if (row.typed != 0) begin
        want[0] = DUTY_W'(row.d1);
        want[1] = DUTY_W'(row.d2);
        want[2] = DUTY_W'(row.d3);
        want[3] = DUTY_W'(row.d4);
      end else begin
        want = limit_to_duty(cmds, rot_en, rot_off);
      end
      send_cmds(cmds, want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      src_idle_pct  = (ph == 0) ? 8 : (ph == 1) ? 58 : 0;
      dst_stall_pct = (ph == 0) ? 58 : (ph == 1) ? 8 : 0;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        en = 1'($urandom_range(1));
        case ($urandom_range(6))
          0: off = '0;
          1: off = OFF_W'(LIMIT);
          2: off = OFF_W'(-LIMIT);
          3: off = {1'b0, {(OFF_W-1){1'b1}}};
          4: off = {1'b1, {(OFF_W-1){1'b0}}};
          5: off = OFF_W'($urandom_range(8191));
          default: off = OFF_W'(int'($urandom_range(2 * LIMIT)) - LIMIT);
        endcase
        set_rotation(en, off);
        for (int k = 0; k < SETS_PER_SETTING; k++) begin
          for (int w = 0; w < NUM_WHEELS; w++) begin
            case ($urandom_range(4))
              0: v = int'($urandom_range(16383));
              1: v = int'($urandom_range(2 * LIMIT)) - LIMIT;
              2: v = ($urandom_range(1) != 0) ? int'($urandom_range(3400, 3000))
                                              : -int'($urandom_range(3400, 3000));
              3: v = EXTREMES[$urandom_range(4)];
              default: v = int'(rot_off) + int'($urandom_range(400)) - 200;
            endcase
            cmds[w] = CMD_IN_W'(v);
          end
          send_cmds(cmds, limit_to_duty(cmds, rot_en, rot_off));
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d wheel command sets across %0d rotation settings; %0d duty sets checked.",
             sets_sent, settings_used, results_checked);
    $display("Covered idle sender with busy receiver, the reverse, and back-to-back traffic.");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
